// ===== design/sld_pkg.sv =====
// shared widths, types and register codes for the structured-light depth block
package sld_pkg;

    localparam int COEF_W   = 48;                    // coefficient registers, Q32.16
    localparam int COL_W    = 12;                    // pixel column and row
    localparam int PC_W     = 20;                    // projector coordinate, Q11.8
    localparam int PMAG_W   = PC_W - 1;              // magnitude of a non-negative coordinate
    localparam int PROD_W   = COEF_W + COL_W + 1;    // coefficient times column or row
    localparam int CD_W     = PROD_W + 1;            // per-pixel C and D terms
    localparam int HALF_W   = CD_W / 2;              // split of D for the D*p product
    localparam int DPL_W    = HALF_W + PMAG_W;
    localparam int DPH_W    = CD_W - HALF_W + PMAG_W + 1;
    localparam int NUM_W    = COEF_W + PC_W;         // numerator B*p - A*256
    localparam int DEN_W    = CD_W + PC_W;           // denominator C*256 - D*p
    localparam int QW       = 24;                    // depth, Q16.8
    localparam int FRAC_W   = 8;                     // the 256 scale of the depth
    localparam int LOW_W    = QW - FRAC_W;           // numerator bits shifted through the divider
    localparam int REG_IDX_W = 3;

    localparam logic [QW-1:0] Z_MIN_DEF = QW'(51200);
    localparam logic [QW-1:0] Z_MAX_DEF = QW'(512000);

    typedef logic signed [COEF_W-1:0] coef_word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CD_W-1:0]   cd_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic signed [DEN_W-1:0]  den_t;
    typedef logic        [DEN_W-1:0]  mag_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_CONST   = 3'd0,
        REG_NUM_SLOPE   = 3'd1,
        REG_DEN_C_CONST = 3'd2,
        REG_DEN_C_COL   = 3'd3,
        REG_DEN_C_ROW   = 3'd4,
        REG_DEN_D_CONST = 3'd5,
        REG_DEN_D_COL   = 3'd6,
        REG_DEN_D_ROW   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        coef_word_t num_const;
        coef_word_t num_slope;
        coef_word_t den_c_const;
        coef_word_t den_c_col;
        coef_word_t den_c_row;
        coef_word_t den_d_const;
        coef_word_t den_d_col;
        coef_word_t den_d_row;
    } coef_t;

    // what one divider cell hands to the next
    typedef struct packed {
        mag_t          rem;   // partial remainder
        mag_t          dvs;   // |denominator|
        logic [QW-1:0] qb;    // dividend bits still to shift in, quotient bits shifting out
        logic          bad;   // result already known to be invalid
    } div_t;

endpackage

// ===== design/sld_prep.sv =====
// front pipeline: per-pixel C and D terms, numerator, denominator and divider setup
module sld_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sld_pkg::coef_t                coef,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [sld_pkg::COL_W-1:0]     pixel_col,
    input  logic [sld_pkg::COL_W-1:0]     pixel_row,
    input  logic signed [sld_pkg::PC_W-1:0] proj_coord,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output sld_pkg::div_t                 dn_data
);

    localparam int NST = 6;

    typedef logic        [sld_pkg::DPL_W-1:0] dpl_t;
    typedef logic signed [sld_pkg::DPH_W-1:0] dph_t;

    logic [NST-1:0] vld_reg, vld_next, adv;

    // stage a: products with column, row and projector coordinate
    sld_pkg::prod_t cu_reg, cu_next, cv_reg, cv_next, du_reg, du_next, dv_reg, dv_next;
    sld_pkg::num_t  np_reg, np_next;
    logic [sld_pkg::PMAG_W-1:0] pa_reg, pa_next;
    logic nega_reg, nega_next;
    logic signed [sld_pkg::COL_W:0] u_s, v_s;

    // stage b: C, D and numerator
    sld_pkg::cd_t  c_reg, c_next, d_reg, d_next;
    sld_pkg::num_t numb_reg, numb_next;
    logic [sld_pkg::PMAG_W-1:0] pb_reg, pb_next;
    logic negb_reg, negb_next;

    // stage c: D*p in two halves
    sld_pkg::cd_t  cc_reg, cc_next;
    logic [sld_pkg::DPL_W-1:0] dpl_reg, dpl_next;
    logic signed [sld_pkg::DPH_W-1:0] dph_reg, dph_next;
    sld_pkg::num_t numc_reg, numc_next;
    logic negc_reg, negc_next;
    logic [sld_pkg::HALF_W-1:0] d_lo;
    logic signed [sld_pkg::CD_W-sld_pkg::HALF_W-1:0] d_hi;
    logic signed [sld_pkg::PMAG_W:0] p_s;

    // stage d: denominator
    sld_pkg::den_t den_reg, den_next;
    sld_pkg::num_t numd_reg, numd_next;
    logic negd_reg, negd_next;

    // stage e: magnitudes and sign checks
    logic [sld_pkg::NUM_W-1:0] an_reg, an_next;
    sld_pkg::mag_t ad_reg, ad_next;
    logic bade_reg, bade_next;

    // stage f: divider setup
    sld_pkg::div_t out_reg, out_next;
    sld_pkg::mag_t rem0;

    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || dn_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? up_valid : vld_reg[0];
        for (int k = 1; k < NST; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_comb begin
        u_s       = $signed({1'b0, pixel_col});
        v_s       = $signed({1'b0, pixel_row});
        cu_next   = sld_pkg::prod_t'(coef.den_c_col) * sld_pkg::prod_t'(u_s);
        cv_next   = sld_pkg::prod_t'(coef.den_c_row) * sld_pkg::prod_t'(v_s);
        du_next   = sld_pkg::prod_t'(coef.den_d_col) * sld_pkg::prod_t'(u_s);
        dv_next   = sld_pkg::prod_t'(coef.den_d_row) * sld_pkg::prod_t'(v_s);
        np_next   = sld_pkg::num_t'(coef.num_slope) * sld_pkg::num_t'(proj_coord);
        pa_next   = proj_coord[sld_pkg::PMAG_W-1:0];
        nega_next = proj_coord[sld_pkg::PC_W-1];
    end

    always_comb begin
        c_next    = sld_pkg::cd_t'(coef.den_c_const) + sld_pkg::cd_t'(cu_reg)
                    + sld_pkg::cd_t'(cv_reg);
        d_next    = sld_pkg::cd_t'(coef.den_d_const) + sld_pkg::cd_t'(du_reg)
                    + sld_pkg::cd_t'(dv_reg);
        numb_next = np_reg - (sld_pkg::num_t'(coef.num_const) <<< sld_pkg::FRAC_W);
        pb_next   = pa_reg;
        negb_next = nega_reg;
    end

    always_comb begin
        d_lo      = d_reg[sld_pkg::HALF_W-1:0];
        d_hi      = d_reg[sld_pkg::CD_W-1:sld_pkg::HALF_W];
        p_s       = $signed({1'b0, pb_reg});
        dpl_next  = dpl_t'(d_lo) * dpl_t'(pb_reg);
        dph_next  = dph_t'(d_hi) * dph_t'(p_s);
        cc_next   = c_reg;
        numc_next = numb_reg;
        negc_next = negb_reg;
    end

    always_comb begin
        den_next  = (sld_pkg::den_t'(cc_reg) <<< sld_pkg::FRAC_W)
                    - ((sld_pkg::den_t'(dph_reg) <<< sld_pkg::HALF_W)
                       + sld_pkg::den_t'(dpl_reg));
        numd_next = numc_reg;
        negd_next = negc_reg;
    end

    always_comb begin
        an_next   = numd_reg[sld_pkg::NUM_W-1] ? $unsigned(-numd_reg) : $unsigned(numd_reg);
        ad_next   = den_reg[sld_pkg::DEN_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
        // no data, zero denominator, or a negative depth
        bade_next = negd_reg || (den_reg == '0)
                    || ((numd_reg != '0)
                        && (numd_reg[sld_pkg::NUM_W-1] != den_reg[sld_pkg::DEN_W-1]));
    end

    always_comb begin
        rem0         = sld_pkg::mag_t'(an_reg[sld_pkg::NUM_W-1:sld_pkg::LOW_W]);
        out_next.rem = rem0;
        out_next.dvs = ad_reg;
        out_next.qb  = {an_reg[sld_pkg::LOW_W-1:0], {sld_pkg::FRAC_W{1'b0}}};
        // quotient needs more than QW bits: beyond any depth limit
        out_next.bad = bade_reg || (rem0 >= ad_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            cu_reg   <= cu_next;
            cv_reg   <= cv_next;
            du_reg   <= du_next;
            dv_reg   <= dv_next;
            np_reg   <= np_next;
            pa_reg   <= pa_next;
            nega_reg <= nega_next;
        end
        if (adv[1]) begin
            c_reg    <= c_next;
            d_reg    <= d_next;
            numb_reg <= numb_next;
            pb_reg   <= pb_next;
            negb_reg <= negb_next;
        end
        if (adv[2]) begin
            cc_reg   <= cc_next;
            dpl_reg  <= dpl_next;
            dph_reg  <= dph_next;
            numc_reg <= numc_next;
            negc_reg <= negc_next;
        end
        if (adv[3]) begin
            den_reg  <= den_next;
            numd_reg <= numd_next;
            negd_reg <= negd_next;
        end
        if (adv[4]) begin
            an_reg   <= an_next;
            ad_reg   <= ad_next;
            bade_reg <= bade_next;
        end
        if (adv[5]) begin
            out_reg  <= out_next;
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = vld_reg[NST-1];
    assign dn_data  = out_reg;

endmodule

// ===== design/sld_div_cell.sv =====
// one restoring-division cell: settles one quotient bit and passes it on
module sld_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          up_valid,
    output logic          up_ready,
    input  sld_pkg::div_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output sld_pkg::div_t dn_data
);

    logic vld_reg, vld_next;
    sld_pkg::div_t data_reg, data_next;
    logic [sld_pkg::DEN_W:0]   trial;
    logic [sld_pkg::DEN_W+1:0] diff;
    logic take;

    always_comb begin
        trial = {up_data.rem, up_data.qb[sld_pkg::QW-1]};
        diff  = {1'b0, trial} - {2'b00, up_data.dvs};
        take  = !diff[sld_pkg::DEN_W+1];
        data_next.rem = take ? diff[sld_pkg::DEN_W-1:0] : trial[sld_pkg::DEN_W-1:0];
        data_next.dvs = up_data.dvs;
        data_next.qb  = {up_data.qb[sld_pkg::QW-2:0], take};
        data_next.bad = up_data.bad;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

// ===== design/structured_light_depth.sv =====
// top level: triangulated depth per camera pixel from the decoded projector coordinate
//
// Input beats on s_* carry one pixel: column, row and signed Q11.8 projector
// coordinate. Each beat gives one result beat on m_*: unsigned Q16.8 depth and
// m_valid_res, with depth 0 when the pixel has no data, the denominator is zero
// or the depth falls outside [Z_MIN, Z_MAX] (Q16.8 units).
// Coefficients are written on cfg_* (index 0..7, 48-bit signed Q32.16 data);
// cfg_ready is always high, and writes belong to times when no pixel is in flight.
// Throughput is one pixel per cycle while m_ready is high. From the input beat to
// m_valid a pixel passes six front stages for products, sums and divider setup,
// a chain of 24 divider cells that each settle one quotient bit, and the output register.
// Every stage holds its own valid bit, so when m_ready is low the pipeline keeps
// taking pixels until each stage is full, and only then drops s_ready.
// Reset empties the pipeline and clears all coefficients to zero.
module structured_light_depth #(
    parameter logic [sld_pkg::QW-1:0] Z_MIN = sld_pkg::Z_MIN_DEF,
    parameter logic [sld_pkg::QW-1:0] Z_MAX = sld_pkg::Z_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sld_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sld_pkg::COEF_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sld_pkg::COL_W-1:0]         s_pixel_col,
    input  logic [sld_pkg::COL_W-1:0]         s_pixel_row,
    input  logic signed [sld_pkg::PC_W-1:0]   s_proj_coord,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sld_pkg::QW-1:0]            m_depth,
    output logic                              m_valid_res
);

    sld_pkg::coef_t coef_reg, coef_next;

    logic          link_valid [sld_pkg::QW+1];
    logic          link_ready [sld_pkg::QW+1];
    sld_pkg::div_t link_data  [sld_pkg::QW+1];

    logic out_valid_reg, out_valid_next, out_adv;
    logic [sld_pkg::QW-1:0] depth_reg, depth_next;
    logic vres_reg, vres_next;
    logic [sld_pkg::QW-1:0] q;
    logic in_range;

    assign cfg_ready = 1'b1;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            unique case (sld_pkg::reg_idx_t'(cfg_index))
                sld_pkg::REG_NUM_CONST:   coef_next.num_const   = cfg_data;
                sld_pkg::REG_NUM_SLOPE:   coef_next.num_slope   = cfg_data;
                sld_pkg::REG_DEN_C_CONST: coef_next.den_c_const = cfg_data;
                sld_pkg::REG_DEN_C_COL:   coef_next.den_c_col   = cfg_data;
                sld_pkg::REG_DEN_C_ROW:   coef_next.den_c_row   = cfg_data;
                sld_pkg::REG_DEN_D_CONST: coef_next.den_d_const = cfg_data;
                sld_pkg::REG_DEN_D_COL:   coef_next.den_d_col   = cfg_data;
                sld_pkg::REG_DEN_D_ROW:   coef_next.den_d_row   = cfg_data;
                default:                  coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    sld_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coef       (coef_reg),
        .up_valid   (s_valid),
        .up_ready   (s_ready),
        .pixel_col  (s_pixel_col),
        .pixel_row  (s_pixel_row),
        .proj_coord (s_proj_coord),
        .dn_valid   (link_valid[0]),
        .dn_ready   (link_ready[0]),
        .dn_data    (link_data[0])
    );

    for (genvar g = 0; g < sld_pkg::QW; g++) begin : g_cell
        sld_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (link_valid[g]),
            .up_ready (link_ready[g]),
            .up_data  (link_data[g]),
            .dn_valid (link_valid[g+1]),
            .dn_ready (link_ready[g+1]),
            .dn_data  (link_data[g+1])
        );
    end

    assign out_adv                 = !out_valid_reg || m_ready;
    assign link_ready[sld_pkg::QW] = out_adv;

    always_comb begin
        q = link_data[sld_pkg::QW].qb;
        // upper limit is exact: equal quotient counts only with no remainder
        in_range = (q >= Z_MIN)
                   && ((q < Z_MAX)
                       || ((q == Z_MAX) && (link_data[sld_pkg::QW].rem == '0)));
        vres_next      = !link_data[sld_pkg::QW].bad && in_range;
        depth_next     = vres_next ? q : '0;
        out_valid_next = out_adv ? link_valid[sld_pkg::QW] : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            depth_reg <= depth_next;
            vres_reg  <= vres_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_depth     = depth_reg;
    assign m_valid_res = vres_reg;

    // an empty output register means every stage can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // divider remainder stays below the divisor for any live pixel
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_valid[sld_pkg::QW] && !link_data[sld_pkg::QW].bad)
        |-> (link_data[sld_pkg::QW].rem < link_data[sld_pkg::QW].dvs))
        else $error("divider remainder out of bound");

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> ((m_depth >= Z_MIN) && (m_depth <= Z_MAX)))
        else $error("valid depth outside limits");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the structured-light depth pipeline
module tb;
    import sld_pkg::*;

    localparam logic [COEF_W-1:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 48'h8000_0000_0000;
    localparam logic [COEF_W-1:0] ONE_Q16  = 48'h0000_0001_0000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 100;
    localparam int TAIL_CYCLES      = 40;

    typedef struct packed {
        logic [QW-1:0] depth;
        logic          in_range;
    } depth_res_t;

    typedef struct {
        bit                      is_coef;
        reg_idx_t                idx;
        logic [COEF_W-1:0]       data;
        logic [COL_W-1:0]        col;
        logic [COL_W-1:0]        row;
        logic signed [PC_W-1:0]  pc;
        bit                      known;
        depth_res_t              want;
    } step_t;

    typedef enum int {ALWAYS_READY, COIN_FLIP, LONG_STALLS} stall_mode_t;
    typedef enum int {STYLE_REAL, STYLE_NOISE, STYLE_EXTREME} coef_style_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [COEF_W-1:0]       cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [COL_W-1:0]        s_pixel_col;
    logic [COL_W-1:0]        s_pixel_row;
    logic signed [PC_W-1:0]  s_proj_coord;
    logic                    m_valid;
    logic                    m_ready;
    logic [QW-1:0]           m_depth;
    logic                    m_valid_res;

    coef_word_t  coefs [8];
    depth_res_t  pending_depths [$];
    depth_res_t  oldest;
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_in_range = 0;
    int          n_settings = 0;

    structured_light_depth DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_col  (s_pixel_col),
        .s_pixel_row  (s_pixel_row),
        .s_proj_coord (s_proj_coord),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_depth      (m_depth),
        .m_valid_res  (m_valid_res)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 400000);
        $display("FAIL structured_light_depth");
        $finish;
    end

    // exact triangulation: z*256 = 256*num/den, kept only inside [Z_MIN, Z_MAX]
    function automatic depth_res_t predict_depth(input logic [COL_W-1:0] col,
                                                 input logic [COL_W-1:0] row,
                                                 input logic signed [PC_W-1:0] pc);
        logic signed [127:0] a, b, c, d, uw, vw, pw, num, den;
        logic [127:0] num_mag, den_mag, scaled;
        depth_res_t res;
        res = '0;
        if (pc < 0)
            return res;
        uw = {116'd0, col};
        vw = {116'd0, row};
        pw = pc;
        a = coefs[REG_NUM_CONST];
        b = coefs[REG_NUM_SLOPE];
        c = coefs[REG_DEN_C_CONST];
        c = c + coefs[REG_DEN_C_COL] * uw + coefs[REG_DEN_C_ROW] * vw;
        d = coefs[REG_DEN_D_CONST];
        d = d + coefs[REG_DEN_D_COL] * uw + coefs[REG_DEN_D_ROW] * vw;
        num = b * pw - a * 256;
        den = c * 256 - d * pw;
        if (den == 0)
            return res;
        // a negative depth never passes
        if (num != 0 && num[127] != den[127])
            return res;
        num_mag = num[127] ? -num : num;
        den_mag = den[127] ? -den : den;
        scaled  = num_mag << FRAC_W;
        if (scaled < den_mag * Z_MIN_DEF || scaled > den_mag * Z_MAX_DEF)
            return res;
        res.depth    = QW'(scaled / den_mag);
        res.in_range = 1'b1;
        return res;
    endfunction

    function automatic step_t coef_step(input reg_idx_t idx, input logic [COEF_W-1:0] data);
        step_t st;
        st = '{idx: REG_NUM_CONST, default: '0};
        st.is_coef = 1'b1;
        st.idx     = idx;
        st.data    = data;
        return st;
    endfunction

    function automatic step_t pix(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                                  input logic signed [PC_W-1:0] pc);
        step_t st;
        st = '{idx: REG_NUM_CONST, default: '0};
        st.col = col;
        st.row = row;
        st.pc  = pc;
        return st;
    endfunction

    function automatic step_t pix_known(input logic [COL_W-1:0] col,
                                        input logic [COL_W-1:0] row,
                                        input logic signed [PC_W-1:0] pc,
                                        input logic [QW-1:0] depth, input logic in_range);
        step_t st;
        st = pix(col, row, pc);
        st.known = 1'b1;
        st.want  = {depth, in_range};
        return st;
    endfunction

    function automatic longint rand_span(input int k);
        return longint'($urandom_range(0, (32'd1 << (k + 1)) - 1)) - (longint'(1) << k);
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic wait_results_drained();
        while (pending_depths.size() != 0)
            @(negedge aclk);
    endtask

    // leaves cfg_valid high so that back-to-back writes run without a gap
    task automatic write_coef(input reg_idx_t idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                              input logic signed [PC_W-1:0] pc, input bit known,
                              input depth_res_t want);
        depth_res_t expected;
        s_valid      <= 1'b1;
        s_pixel_col  <= col;
        s_pixel_row  <= row;
        s_proj_coord <= pc;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected = known ? want : predict_depth(col, row, pc);
        pending_depths.push_back(expected);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic load_random_coefs(input coef_style_t style);
        coef_word_t vals [8];
        longint cc, z0;
        case (style)
            STYLE_REAL: begin
                // C near 4096.0 so that small D, col and row terms bend z around z0
                cc = (longint'(1) << 28) + rand_span(26);
                z0 = $urandom_range(150, 2100);
                vals[REG_DEN_C_CONST] = COEF_W'(cc);
                vals[REG_DEN_C_COL]   = COEF_W'(rand_span(14));
                vals[REG_DEN_C_ROW]   = COEF_W'(rand_span(14));
                vals[REG_DEN_D_CONST] = COEF_W'(rand_span(16));
                vals[REG_DEN_D_COL]   = COEF_W'(rand_span(2));
                vals[REG_DEN_D_ROW]   = COEF_W'(rand_span(2));
                vals[REG_NUM_CONST]   = COEF_W'(-(z0 * cc));
                vals[REG_NUM_SLOPE]   = COEF_W'(rand_span(22));
            end
            STYLE_NOISE: begin
                foreach (vals[i])
                    vals[i] = COEF_W'({$urandom, $urandom});
            end
            default: begin
                foreach (vals[i])
                    vals[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_coef(reg_idx_t'(i), vals[i]);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // receiver: changes its stall habit after each random span
    initial begin : ready_pattern
        stall_mode_t mode;
        int span;
        int stall;
        m_ready = 1'b0;
        stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            mode = stall_mode_t'($urandom_range(0, 2));
            span = $urandom_range(100, 300);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    ALWAYS_READY: m_ready <= 1'b1;
                    COIN_FLIP:    m_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall == 0 && $urandom_range(0, 7) == 0)
                            stall = $urandom_range(1, 48);
                        if (stall > 0) begin
                            m_ready <= 1'b0;
                            stall--;
                        end else begin
                            m_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (coefs[i])
                coefs[i] <= '0;
        end else begin
            if (cfg_valid && cfg_ready)
                coefs[cfg_index] <= cfg_data;
            if (m_valid && m_ready) begin
                n_results++;
                if (pending_depths.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing pending", n_results));
                end else begin
                    oldest = pending_depths.pop_front();
                    if (oldest.in_range)
                        n_in_range++;
                    if (m_depth !== oldest.depth)
                        report_mismatch($sformatf("beat %0d: depth %0d, expected %0d",
                                                  n_results, m_depth, oldest.depth));
                    if (m_valid_res !== oldest.in_range)
                        report_mismatch($sformatf("beat %0d: valid_res %b, expected %b",
                                                  n_results, m_valid_res, oldest.in_range));
                end
            end
        end
    end

    initial begin : stimulus
        step_t script [$];
        step_t st;
        int burst_left;
        logic [COL_W-1:0] col, row;
        logic signed [PC_W-1:0] pc;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_pixel_col  = '0;
        s_pixel_row  = '0;
        s_proj_coord = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;

        // all coefficients zero after reset: denominator is zero everywhere
        script.push_back(pix_known(0, 0, 0, 0, 1'b0));
        script.push_back(pix_known(4095, 4095, 524287, 0, 1'b0));
        script.push_back(pix_known(123, 456, -1, 0, 1'b0));
        // A=0, B=1.0, C=1.0, D=0: depth equals the projector coordinate
        script.push_back(coef_step(REG_NUM_SLOPE, ONE_Q16));
        script.push_back(coef_step(REG_DEN_C_CONST, ONE_Q16));
        script.push_back(pix_known(0, 0, 51200, 51200, 1'b1));
        script.push_back(pix_known(4095, 4095, 512000, 512000, 1'b1));
        script.push_back(pix_known(7, 9, 51199, 0, 1'b0));
        script.push_back(pix_known(7, 9, 512001, 0, 1'b0));
        script.push_back(pix_known(1, 2, 0, 0, 1'b0));
        script.push_back(pix_known(2048, 2048, -524288, 0, 1'b0));
        script.push_back(pix_known(100, 200, 300000, 300000, 1'b1));
        script.push_back(pix_known(0, 0, 524287, 0, 1'b0));
        // D=1.0: denominator vanishes at p=1.0, flips sign beyond it
        script.push_back(coef_step(REG_DEN_D_CONST, ONE_Q16));
        script.push_back(pix_known(5, 5, 256, 0, 1'b0));
        script.push_back(pix(5, 5, 100));
        script.push_back(pix_known(5, 5, 300, 0, 1'b0));
        // constant depth 300.0 at the origin, growing column and row terms
        script.push_back(coef_step(REG_NUM_CONST, COEF_W'(-19660800)));
        script.push_back(coef_step(REG_NUM_SLOPE, '0));
        script.push_back(coef_step(REG_DEN_D_CONST, '0));
        script.push_back(coef_step(REG_DEN_C_COL, 48'd16));
        script.push_back(coef_step(REG_DEN_C_ROW, 48'd32));
        script.push_back(pix_known(0, 0, 1000, 76800, 1'b1));
        script.push_back(pix(4095, 4095, 1000));
        script.push_back(pix(2048, 17, 77));
        for (int i = 0; i < 8; i++)
            script.push_back(coef_step(reg_idx_t'(i), COEF_MAX));
        script.push_back(pix(4095, 4095, 524287));
        script.push_back(pix(0, 0, 0));
        for (int i = 0; i < 8; i++)
            script.push_back(coef_step(reg_idx_t'(i), COEF_MIN));
        script.push_back(pix(4095, 0, 1));
        script.push_back(pix(0, 4095, 524287));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            st = script[i];
            if (st.is_coef) begin
                // first write of a group waits for the pipeline to empty
                if (!cfg_valid) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    wait_results_drained();
                    n_settings++;
                end
                write_coef(st.idx, st.data);
            end else begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                send_pixel(st.col, st.row, st.pc, st.known, st.want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            wait_results_drained();
            if (ph == 3)
                load_random_coefs(STYLE_NOISE);
            else if (ph == 6)
                load_random_coefs(STYLE_EXTREME);
            else
                load_random_coefs(STYLE_REAL);
            burst_left = 0;
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 8);
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    if ($urandom_range(0, 39) == 0)
                        wait_results_drained();
                    else
                        repeat ($urandom_range(0, 5)) @(negedge aclk);
                end
                burst_left--;
                col = COL_W'($urandom_range(0, 4095));
                row = COL_W'($urandom_range(0, 4095));
                case ($urandom_range(0, 19))
                    0, 1, 2: pc = PC_W'($urandom_range(524288, 1048575));
                    3:       pc = '0;
                    4:       pc = 20'h7FFFF;
                    default: pc = PC_W'($urandom_range(0, 524287));
                endcase
                send_pixel(col, row, pc, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("checked %0d pixels under %0d coefficient settings, %0d depths in range",
                 n_sent, n_settings, n_in_range);
        if (n_errors == 0)
            $display("PASS structured_light_depth");
        else
            $display("FAIL structured_light_depth");
        $finish;
    end

endmodule

// ===== files.f =====
design/sld_pkg.sv
design/sld_prep.sv
design/sld_div_cell.sv
design/structured_light_depth.sv
tb/sv/tb.sv
